// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: hw/rtl/lsrl_pkg.sv
// Package: types, constants and the ramp curve function for the speed ramp / line steer block
`timescale 1ns / 1ps

package lsrl_pkg;

  localparam int RAMP_TABLE_DEPTH_DEF = 256;
  localparam int SPEED_FULL_SCALE_DEF = 30;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_ADDR_W-1:0] CFG_MIN_DRIVE     = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_DRIVE     = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_REVERSE_DRIVE = 2'd2;

  localparam logic [7:0] MIN_DRIVE_RST     = 8'd75;
  localparam logic [7:0] MAX_DRIVE_RST     = 8'd255;
  localparam logic [7:0] REVERSE_DRIVE_RST = 8'd120;

  localparam logic [11:0] RAMP_TIME_MAX = 12'hFFF;
  // a received byte of one stands for a limit of zero
  localparam logic [7:0] ZERO_LIMIT_CODE = 8'd1;

  localparam logic [7:0] TGT_RED   = 8'd0;
  localparam logic [7:0] TGT_GREEN = 8'd5;
  localparam logic [7:0] TGT_BLUE  = 8'd11;
  localparam logic [7:0] TGT_WHITE = 8'd20;

  localparam logic [2:0] LED_OFF   = 3'd0;
  localparam logic [2:0] LED_RED   = 3'd1;
  localparam logic [2:0] LED_GREEN = 3'd2;
  localparam logic [2:0] LED_BLUE  = 3'd3;
  localparam logic [2:0] LED_WHITE = 3'd4;

  localparam logic [63:0] ONE_Q32      = 64'h1_0000_0000;
  localparam logic [63:0] EXP_STEP_Q32 = 64'd4126559220;
  localparam logic [63:0] HALF_Q32     = 64'h8000_0000;

  typedef struct packed {
    logic [7:0]  target_limit;
    logic [7:0]  start_limit;
    logic [11:0] ramp_time;
    logic [2:0]  led_code;
  } state_t;

  // Logistic curve entry in Q0.16 at t = 16*idx ms; evaluated at elaboration only.
  function automatic logic [15:0] curve_entry(input int unsigned idx);
    logic [63:0] p;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] rem;
    logic [63:0] h;
    int unsigned k;
    int unsigned i;
    int b;
    if (2 * idx < 125) k = 125 - 2 * idx;
    else k = 2 * idx - 125;
    p = ONE_Q32;
    for (i = 0; i < k; i++) p = (p * EXP_STEP_Q32 + HALF_Q32) >> 32;
    num = (p << 16) + ((ONE_Q32 + p) >> 1);
    den = ONE_Q32 + p;
    // restoring division, quotient fits well below 2^49
    rem = '0;
    h = '0;
    for (b = 48; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem  = rem - den;
        h[b] = 1'b1;
      end
    end
    if (2 * idx < 125) return h[15:0];
    h = 64'd65536 - h;
    if (h > 64'd65535) return 16'hFFFF;
    return h[15:0];
  endfunction

endpackage

// File: hw/rtl/lsrl_in_if.sv
// Input channel interface: one control pass per transaction
`timescale 1ns / 1ps

interface lsrl_in_if;
  logic       valid;
  logic       ready;
  logic       byte_valid;
  logic [7:0] speed_byte;
  logic [9:0] elapsed_ms;
  logic       left_line;
  logic       right_line;

  modport source (
    output valid, byte_valid, speed_byte, elapsed_ms, left_line, right_line,
    input  ready
  );
  modport sink (
    input  valid, byte_valid, speed_byte, elapsed_ms, left_line, right_line,
    output ready
  );
endinterface

// File: hw/rtl/lsrl_out_if.sv
// Result channel interface: drive commands, LED code and echo per transaction
`timescale 1ns / 1ps

interface lsrl_out_if;
  logic              valid;
  logic              ready;
  logic signed [8:0] left_drive;
  logic signed [8:0] right_drive;
  logic [2:0]        led_color;
  logic              echo_valid;
  logic [7:0]        echo_value;

  modport source (
    output valid, left_drive, right_drive, led_color, echo_valid, echo_value,
    input  ready
  );
  modport sink (
    input  valid, left_drive, right_drive, led_color, echo_valid, echo_value,
    output ready
  );
endinterface

// File: hw/rtl/lsrl_state_mem.sv
// Single-entry state memory with registered read and a reset-cleared valid bit
`timescale 1ns / 1ps

module lsrl_state_mem (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            rd_en,
  input  logic            wr_en,
  input  lsrl_pkg::state_t wr_data,
  output lsrl_pkg::state_t rd_data
);

  lsrl_pkg::state_t mem_r [1];
  lsrl_pkg::state_t rd_q_r;
  logic             vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (wr_en) begin
      vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[0] <= wr_data;
    end
    // an entry never written reads as the reset state
    if (rd_en) begin
      rd_q_r <= vld_r ? mem_r[0] : '0;
    end
  end

  assign rd_data = rd_q_r;

endmodule

// File: hw/rtl/lsrl_ramp_rom.sv
// Logistic ramp curve ROM, Q0.16 entries, registered read
`timescale 1ns / 1ps

module lsrl_ramp_rom #(
  parameter int DEPTH = lsrl_pkg::RAMP_TABLE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] addr,
  output logic [15:0]              rd_data
);

  logic [15:0] rom [DEPTH];
  logic [15:0] rd_q_r;

  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_rom
    localparam logic [15:0] ENTRY = lsrl_pkg::curve_entry(gi);
    assign rom[gi] = ENTRY;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r <= rom[addr];
    end
  end

  assign rd_data = rd_q_r;

endmodule

// File: hw/rtl/logistic_speed_ramp_line_steer.sv
// Top level: speed ramp along a logistic curve, drive mapping and line sensor steering
// A result is registered after states S_UPD, S_SPD, S_PROD, S_DIV and S_OUT in turn.
// One transaction at a time: input ready only in S_IDLE; the pass is the state read-modify-write,
//   the curve ROM read and three chained multiply stages (ramp, range, divide by full scale).
// A finished result may wait in the output register while the next transaction is taken.
// Reset (rst_n low, synchronous): state reads as zero, config 75/255/120.
`timescale 1ns / 1ps

module logistic_speed_ramp_line_steer #(
  parameter int RAMP_TABLE_DEPTH = lsrl_pkg::RAMP_TABLE_DEPTH_DEF,
  parameter int SPEED_FULL_SCALE = lsrl_pkg::SPEED_FULL_SCALE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  lsrl_in_if.sink                         in_ch,
  lsrl_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [lsrl_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [lsrl_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(RAMP_TABLE_DEPTH);
  // divide by full scale as multiply by rounded-up reciprocal, exact for |x| < 2^17
  localparam int DIV_SHIFT = 25;
  localparam logic [25:0] DIV_RECIP =
    26'(((2 ** DIV_SHIFT) + SPEED_FULL_SCALE - 1) / SPEED_FULL_SCALE);

  typedef enum logic [2:0] {
    S_IDLE, S_UPD, S_SPD, S_PROD, S_DIV, S_OUT
  } fsm_t;

  fsm_t state_r, state_nxt;

  logic [7:0] min_r, max_r, rev_r;

  logic       bv_r, lline_r, rline_r;
  logic [7:0] sbyte_r;
  logic [9:0] elap_r;

  logic [7:0] tgt_r, tgt_nxt, start_r, start_nxt;
  logic       echo_v_r, echo_v_nxt;
  logic [7:0] echo_val_r, echo_val_nxt;
  logic [2:0] led_r, led_nxt;

  logic [7:0]         s_r, s_nxt;
  logic signed [17:0] sprod_r, sprod_nxt;
  logic [16:0]        qmag_r, qmag_nxt;
  logic               qneg_r, qneg_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic signed [8:0] left_r, left_nxt, right_r, right_nxt;
  logic [2:0]        led_out_r, led_out_nxt;
  logic              echo_out_r, echo_out_nxt;
  logic [7:0]        echo_val_out_r, echo_val_out_nxt;

  logic             st_rd, st_wr;
  lsrl_pkg::state_t st_wdata, st_q;
  logic             rom_rd;
  logic [IDX_W-1:0] rom_addr;
  logic [15:0]      rom_q;

  logic               in_take, out_take;
  logic [12:0]        rt_sum;
  logic [11:0]        rt_new;
  logic [7:0]         idx_full;
  logic signed [25:0] f_ext, diff_ext, fprod, spd_sum;
  logic signed [17:0] s_ext, range_ext;
  logic [17:0]        mag;
  logic [42:0]        divp;
  logic signed [18:0] qs, d, lo_s, hi_s;
  logic [7:0]         drv;
  logic signed [8:0]  drive_s, rev_s;

  lsrl_state_mem u_state_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (st_rd),
    .wr_en   (st_wr),
    .wr_data (st_wdata),
    .rd_data (st_q)
  );

  lsrl_ramp_rom #(
    .DEPTH (RAMP_TABLE_DEPTH)
  ) u_ramp_rom (
    .clk     (clk),
    .rd_en   (rom_rd),
    .addr    (rom_addr),
    .rd_data (rom_q)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_take     = in_ch.valid && in_ch.ready;
  assign out_take    = out_valid_r && out_ch.ready;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.left_drive  = left_r;
  assign out_ch.right_drive = right_r;
  assign out_ch.led_color   = led_out_r;
  assign out_ch.echo_valid  = echo_out_r;
  assign out_ch.echo_value  = echo_val_out_r;

  always_comb begin
    state_nxt        = state_r;
    tgt_nxt          = tgt_r;
    start_nxt        = start_r;
    echo_v_nxt       = echo_v_r;
    echo_val_nxt     = echo_val_r;
    led_nxt          = led_r;
    s_nxt            = s_r;
    sprod_nxt        = sprod_r;
    qmag_nxt         = qmag_r;
    qneg_nxt         = qneg_r;
    out_valid_nxt    = out_valid_r && !out_take;
    left_nxt         = left_r;
    right_nxt        = right_r;
    led_out_nxt      = led_out_r;
    echo_out_nxt     = echo_out_r;
    echo_val_out_nxt = echo_val_out_r;
    st_rd            = 1'b0;
    st_wr            = 1'b0;
    rom_rd           = 1'b0;

    // state update: timer, byte handling, LED
    rt_sum = {1'b0, st_q.ramp_time} + {3'b000, elap_r};
    rt_new = rt_sum[12] ? lsrl_pkg::RAMP_TIME_MAX : rt_sum[11:0];
    st_wdata.target_limit = st_q.target_limit;
    st_wdata.start_limit  = st_q.start_limit;
    st_wdata.ramp_time    = rt_new;
    st_wdata.led_code     = st_q.led_code;
    if (bv_r) begin
      st_wdata.start_limit = st_q.target_limit;
      if (sbyte_r != st_q.target_limit) begin
        st_wdata.target_limit = (sbyte_r == lsrl_pkg::ZERO_LIMIT_CODE) ? '0 : sbyte_r;
        st_wdata.ramp_time    = '0;
      end
    end
    case (st_wdata.target_limit)
      lsrl_pkg::TGT_RED:   st_wdata.led_code = lsrl_pkg::LED_RED;
      lsrl_pkg::TGT_GREEN: st_wdata.led_code = lsrl_pkg::LED_GREEN;
      lsrl_pkg::TGT_BLUE:  st_wdata.led_code = lsrl_pkg::LED_BLUE;
      lsrl_pkg::TGT_WHITE: st_wdata.led_code = lsrl_pkg::LED_WHITE;
      default: ;
    endcase
    idx_full = st_wdata.ramp_time[11:4];
    if (32'(idx_full) > RAMP_TABLE_DEPTH - 1) rom_addr = IDX_W'(RAMP_TABLE_DEPTH - 1);
    else rom_addr = IDX_W'(idx_full);

    // ramp: start + f*(target-start), never negative, so >>16 is the truncation
    f_ext    = {10'b0, rom_q};
    diff_ext = $signed({18'b0, tgt_r}) - $signed({18'b0, start_r});
    fprod    = f_ext * diff_ext;
    spd_sum  = $signed({2'b00, start_r, 16'h0000}) + fprod;

    // drive slope
    s_ext     = {10'b0, s_r};
    range_ext = $signed({10'b0, max_r}) - $signed({10'b0, min_r});

    // truncating divide by full scale on the magnitude
    mag  = sprod_r[17] ? 18'(-sprod_r) : 18'(sprod_r);
    divp = 43'(mag[16:0]) * 43'(DIV_RECIP);

    qs   = qneg_r ? -$signed({2'b00, qmag_r}) : $signed({2'b00, qmag_r});
    lo_s = $signed({11'b0, min_r});
    hi_s = $signed({11'b0, max_r});
    d    = qs + lo_s;
    if (d <= lo_s) drv = '0;
    else if (d >= hi_s) drv = max_r;
    else drv = d[7:0];
    drive_s = $signed({1'b0, drv});
    rev_s   = -$signed({1'b0, rev_r});

    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          st_rd     = 1'b1;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        st_wr        = 1'b1;
        rom_rd       = 1'b1;
        tgt_nxt      = st_wdata.target_limit;
        start_nxt    = st_wdata.start_limit;
        led_nxt      = st_wdata.led_code;
        echo_v_nxt   = bv_r && (sbyte_r != st_q.target_limit);
        echo_val_nxt = echo_v_nxt ? st_wdata.target_limit : '0;
        state_nxt    = S_SPD;
      end
      S_SPD: begin
        s_nxt     = spd_sum[23:16];
        state_nxt = S_PROD;
      end
      S_PROD: begin
        sprod_nxt = s_ext * range_ext;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        qmag_nxt  = divp[DIV_SHIFT +: 17];
        qneg_nxt  = sprod_r[17];
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // hold while the previous result is still waiting
        if (!out_valid_r || out_take) begin
          out_valid_nxt    = 1'b1;
          left_nxt         = drive_s;
          right_nxt        = drive_s;
          if (lline_r && rline_r) begin
            left_nxt  = rev_s;
            right_nxt = rev_s;
          end else if (rline_r) begin
            left_nxt = '0;
          end else if (lline_r) begin
            right_nxt = '0;
          end
          led_out_nxt      = led_r;
          echo_out_nxt     = echo_v_r;
          echo_val_out_nxt = echo_val_r;
          state_nxt        = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      min_r       <= lsrl_pkg::MIN_DRIVE_RST;
      max_r       <= lsrl_pkg::MAX_DRIVE_RST;
      rev_r       <= lsrl_pkg::REVERSE_DRIVE_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          lsrl_pkg::CFG_MIN_DRIVE:     min_r <= cfg_wdata;
          lsrl_pkg::CFG_MAX_DRIVE:     max_r <= cfg_wdata;
          lsrl_pkg::CFG_REVERSE_DRIVE: rev_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
    if (in_take) begin
      bv_r    <= in_ch.byte_valid;
      sbyte_r <= in_ch.speed_byte;
      elap_r  <= in_ch.elapsed_ms;
      lline_r <= in_ch.left_line;
      rline_r <= in_ch.right_line;
    end
    tgt_r          <= tgt_nxt;
    start_r        <= start_nxt;
    echo_v_r       <= echo_v_nxt;
    echo_val_r     <= echo_val_nxt;
    led_r          <= led_nxt;
    s_r            <= s_nxt;
    sprod_r        <= sprod_nxt;
    qmag_r         <= qmag_nxt;
    qneg_r         <= qneg_nxt;
    left_r         <= left_nxt;
    right_r        <= right_nxt;
    led_out_r      <= led_out_nxt;
    echo_out_r     <= echo_out_nxt;
    echo_val_out_r <= echo_val_out_nxt;
  end

endmodule

// File: hw/rtl/lsrl_checker.sv
// Port-level checker for the speed ramp / line steer top level, with its bind
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lsrl_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [8:0] left_drive,
  input logic signed [8:0] right_drive,
  input logic [2:0]        led_color,
  input logic              echo_valid,
  input logic [7:0]        echo_value
);

  // one transaction in flight: ready drops right after a take
  `ASSERT_AT(a_one_in_flight, clk, rst_n, in_valid && in_ready |=> !in_ready, "input taken while busy")
  // a stalled result keeps its drive values
  `ASSERT_AT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(left_drive) && $stable(right_drive), "stalled result changed")
  // no echo means the echo byte is zero
  `ASSERT_NEVER(a_echo_zero, clk, rst_n, out_valid && !echo_valid && echo_value != 8'd0, "echo value without echo")
  `ASSERT_NEVER(a_led_range, clk, rst_n, out_valid && led_color > 3'd4, "LED code out of range")
  // reverse only ever happens on both sides at once
  `ASSERT_AT(a_reverse_pair, clk, rst_n, out_valid && (left_drive[8] || right_drive[8]) |-> left_drive == right_drive, "one-sided reverse")

endmodule

bind logistic_speed_ramp_line_steer lsrl_checker u_lsrl_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .left_drive  (out_ch.left_drive),
  .right_drive (out_ch.right_drive),
  .led_color   (out_ch.led_color),
  .echo_valid  (out_ch.echo_valid),
  .echo_value  (out_ch.echo_value)
);
